[hw/rtl/lru_frame_replacer_with_pins_assert.svh]
// Assertion macros for the LRU frame replacer.
// Expects signals named clk and arst_n in the module that uses them.
`ifndef LRU_FRAME_REPLACER_WITH_PINS_ASSERT_SVH
`define LRU_FRAME_REPLACER_WITH_PINS_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LFR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LFR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LFR_ASSERT_IMP(lbl, ante, cons, msg)
`define LFR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/lfr_pkg.sv]
// Shared constants and types of the LRU frame replacer.
// No dependencies; used by lfr_cell and the top level.
package lfr_pkg;
	localparam int NUM_FRAMES_DEF   = 16;
	localparam int PAGE_ID_BITS_DEF = 32;

	localparam int PORT_PAGE_W = 32;
	localparam int FRAME_W     = 4;
	localparam int STATUS_W    = 2;
	localparam int CMD_W       = 2;
	localparam int POOL_W      = 5;
	localparam int IN_DATA_W   = 40;
	localparam int OUT_DATA_W  = 40;

	localparam logic [POOL_W-1:0] POOL_RESET = 5'd16;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TOUCH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PIN   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNPIN = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_ALL_PINNED   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NOT_RESIDENT = 2'd2;

	// update broadcast to every cell at the end of an item
	typedef enum logic [1:0] {
		UPD_NONE  = 2'd0,
		UPD_FRESH = 2'd1,
		UPD_FRONT = 2'd2,
		UPD_PIN   = 2'd3
	} upd_op_t;
endpackage

[hw/rtl/lfr_cell.sv]
// One frame cell: page, valid, pin mark and recency rank of a single frame.
// Passes the lookup/victim search record to the next cell each cycle. Uses lfr_pkg.
module lfr_cell #(
	parameter int NUM_FRAMES   = lfr_pkg::NUM_FRAMES_DEF,
	parameter int PAGE_ID_BITS = lfr_pkg::PAGE_ID_BITS_DEF,
	localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1,
	localparam int REC_W = 2 + 4 * IDX_W + PAGE_ID_BITS,
	localparam int UPD_W = 4 + 2 * IDX_W + PAGE_ID_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [IDX_W-1:0]        cell_idx,
	input  logic [PAGE_ID_BITS-1:0] key,
	input  logic [REC_W-1:0]        rec_in,
	output logic [REC_W-1:0]        rec_out,
	input  logic [UPD_W-1:0]        upd_in
);
	typedef struct packed {
		logic                    hit;
		logic [IDX_W-1:0]        hit_idx;
		logic [IDX_W-1:0]        hit_rank;
		logic                    vic;
		logic [IDX_W-1:0]        vic_idx;
		logic [IDX_W-1:0]        vic_rank;
		logic [PAGE_ID_BITS-1:0] vic_page;
	} rec_t;

	typedef struct packed {
		lfr_pkg::upd_op_t        op;
		logic [IDX_W-1:0]        idx;
		logic [IDX_W-1:0]        rank;
		logic                    wr;
		logic                    pin;
		logic [PAGE_ID_BITS-1:0] page;
	} upd_t;

	rec_t ri;
	rec_t rnext;
	rec_t rec_q;
	upd_t u;
	logic self;

	logic                    valid_q;
	logic                    pinned_q;
	logic [IDX_W-1:0]        rank_q;
	logic [PAGE_ID_BITS-1:0] page_q;

	assign ri      = rec_in;
	assign u       = upd_in;
	assign rec_out = rec_q;
	assign self    = (u.idx == cell_idx);

	always_comb begin
		rnext = ri;
		// first matching cell wins
		if (valid_q && (page_q == key) && !ri.hit) begin
			rnext.hit      = 1'b1;
			rnext.hit_idx  = cell_idx;
			rnext.hit_rank = rank_q;
		end
		// oldest unpinned frame so far
		if (valid_q && !pinned_q && (!ri.vic || (rank_q > ri.vic_rank))) begin
			rnext.vic      = 1'b1;
			rnext.vic_idx  = cell_idx;
			rnext.vic_rank = rank_q;
			rnext.vic_page = page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else begin
			rec_q <= rnext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			pinned_q <= 1'b0;
			rank_q   <= '0;
		end else begin
			case (u.op)
				lfr_pkg::UPD_FRESH: begin
					if (self) begin
						valid_q  <= 1'b1;
						pinned_q <= u.pin;
						rank_q   <= '0;
					end else if (valid_q) begin
						rank_q <= rank_q + 1'b1;
					end
				end
				lfr_pkg::UPD_FRONT: begin
					if (self) begin
						rank_q <= '0;
						if (u.wr) begin
							pinned_q <= u.pin;
						end
					end else if (valid_q && (rank_q < u.rank)) begin
						rank_q <= rank_q + 1'b1;
					end
				end
				lfr_pkg::UPD_PIN: begin
					if (self) begin
						pinned_q <= u.pin;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (self && ((u.op == lfr_pkg::UPD_FRESH) || ((u.op == lfr_pkg::UPD_FRONT) && u.wr))) begin
			page_q <= u.page;
		end
	end
endmodule

[hw/rtl/lru_frame_replacer_with_pins.sv]
// Top level of the LRU frame replacer with pinned frames.
// Uses lfr_pkg, lfr_cell and lru_frame_replacer_with_pins_assert.svh.

// Buffer-pool frame replacer. Each command (allocate, touch, pin, unpin) runs to
// completion before the next input transfer is accepted: a search record walks
// the row of frame cells one cell per cycle, finding the resident page and the
// least recently used unpinned frame, then the apply step applies the update to
// all cells and loads the result register. A result that has not been taken
// stalls only the update step. Reset clears all frames; the pool size resets to
// 16; the user must write it through the cfg channel only while the block is
// idle, as the block itself does not enforce this.
`include "lru_frame_replacer_with_pins_assert.svh"
module lru_frame_replacer_with_pins #(
	parameter int NUM_FRAMES   = lfr_pkg::NUM_FRAMES_DEF,
	parameter int PAGE_ID_BITS = lfr_pkg::PAGE_ID_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [lfr_pkg::IN_DATA_W-1:0]    s_tdata,  // page_id[31:0], pin_on_load[32], zero pad
	input  logic [lfr_pkg::CMD_W-1:0]        s_tuser,  // command[1:0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [lfr_pkg::OUT_DATA_W-1:0]   m_tdata,  // frame[3:0], evicted[4], evicted_page[36:5], pad
	output logic [lfr_pkg::STATUS_W-1:0]     m_tuser,  // status[1:0]
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lfr_pkg::POOL_W-1:0]       cfg_data
);
	localparam int IDX_W   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int CNT_W   = $clog2(NUM_FRAMES + 1);
	localparam int POOL_W  = lfr_pkg::POOL_W;
	localparam int LIM_W   = (CNT_W > POOL_W) ? CNT_W : POOL_W;
	localparam int PORT_PW = lfr_pkg::PORT_PAGE_W;
	localparam int WIDE    = (PAGE_ID_BITS > PORT_PW) ? PAGE_ID_BITS : PORT_PW;
	localparam int FRAME_W = lfr_pkg::FRAME_W;
	localparam int REC_W   = 2 + 4 * IDX_W + PAGE_ID_BITS;
	localparam int UPD_W   = 4 + 2 * IDX_W + PAGE_ID_BITS;
	localparam int PAD_IN  = lfr_pkg::OUT_DATA_W - FRAME_W - 1 - PORT_PW;

	typedef struct packed {
		logic                    hit;
		logic [IDX_W-1:0]        hit_idx;
		logic [IDX_W-1:0]        hit_rank;
		logic                    vic;
		logic [IDX_W-1:0]        vic_idx;
		logic [IDX_W-1:0]        vic_rank;
		logic [PAGE_ID_BITS-1:0] vic_page;
	} rec_t;

	typedef struct packed {
		lfr_pkg::upd_op_t        op;
		logic [IDX_W-1:0]        idx;
		logic [IDX_W-1:0]        rank;
		logic                    wr;
		logic                    pin;
		logic [PAGE_ID_BITS-1:0] page;
	} upd_t;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SWEEP = 3'b010,
		S_APPLY = 3'b100
	} fsm_t;

	fsm_t                          state_q;
	logic [IDX_W-1:0]              cnt_q;
	logic [lfr_pkg::CMD_W-1:0]     cmd_q;
	logic [PAGE_ID_BITS-1:0]       key_q;
	logic                          pin_q;
	logic [POOL_W-1:0]             pool_q;
	logic [CNT_W-1:0]              used_q;
	logic                          m_tvalid_q;
	logic [FRAME_W-1:0]            frame_q;
	logic [lfr_pkg::STATUS_W-1:0]  status_q;
	logic                          ev_q;
	logic [PORT_PW-1:0]            evpage_q;

	logic [REC_W-1:0] link [NUM_FRAMES+1];
	rec_t             fin;
	upd_t             upd;

	logic [WIDE-1:0]              key_wide;
	logic [WIDE-1:0]              ev_wide;
	logic [LIM_W-1:0]             pool_ext;
	logic [LIM_W-1:0]             nmax;
	logic [LIM_W-1:0]             limit;
	logic                         fresh;
	logic                         out_free;
	logic                         apply_go;
	logic [IDX_W-1:0]             nfr;
	logic [lfr_pkg::STATUS_W-1:0] nstat;
	logic                         nev;
	logic [PAGE_ID_BITS-1:0]      nevp;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {{PAD_IN{1'b0}}, evpage_q, ev_q, frame_q};
	assign m_tuser   = status_q;

	assign out_free = !m_tvalid_q || m_tready;
	assign apply_go = (state_q == S_APPLY) && out_free;
	assign key_wide = WIDE'(s_tdata[PORT_PW-1:0]);
	assign ev_wide  = WIDE'(nevp);

	// pool size 0 acts as 1, above NUM_FRAMES as NUM_FRAMES
	assign pool_ext = LIM_W'(pool_q);
	assign nmax     = LIM_W'(NUM_FRAMES);
	assign limit    = (pool_q == '0) ? LIM_W'(1) : ((pool_ext > nmax) ? nmax : pool_ext);
	assign fresh    = (LIM_W'(used_q) < limit);

	// search record enters the row empty
	assign link[0] = '0;
	assign fin     = link[NUM_FRAMES];

	for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
		lfr_cell #(
			.NUM_FRAMES  (NUM_FRAMES),
			.PAGE_ID_BITS(PAGE_ID_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cell_idx(IDX_W'(g)),
			.key     (key_q),
			.rec_in  (link[g]),
			.rec_out (link[g+1]),
			.upd_in  (upd)
		);
	end

	always_comb begin
		upd.op   = lfr_pkg::UPD_NONE;
		upd.idx  = '0;
		upd.rank = '0;
		upd.wr   = 1'b0;
		upd.pin  = 1'b0;
		upd.page = key_q;
		nfr      = '0;
		nstat    = lfr_pkg::STAT_OK;
		nev      = 1'b0;
		nevp     = '0;
		if (!fin.hit) begin
			if (cmd_q == lfr_pkg::CMD_ALLOC) begin
				if (fresh) begin
					upd.op  = lfr_pkg::UPD_FRESH;
					upd.idx = used_q[IDX_W-1:0];
					upd.pin = pin_q;
					nfr     = used_q[IDX_W-1:0];
				end else if (fin.vic) begin
					upd.op   = lfr_pkg::UPD_FRONT;
					upd.idx  = fin.vic_idx;
					upd.rank = fin.vic_rank;
					upd.wr   = 1'b1;
					upd.pin  = pin_q;
					nfr      = fin.vic_idx;
					nev      = 1'b1;
					nevp     = fin.vic_page;
				end else begin
					nstat = lfr_pkg::STAT_ALL_PINNED;
				end
			end else begin
				nstat = lfr_pkg::STAT_NOT_RESIDENT;
			end
		end else begin
			nfr     = fin.hit_idx;
			upd.idx = fin.hit_idx;
			case (cmd_q)
				lfr_pkg::CMD_ALLOC, lfr_pkg::CMD_TOUCH: begin
					upd.op   = lfr_pkg::UPD_FRONT;
					upd.rank = fin.hit_rank;
				end
				lfr_pkg::CMD_PIN: begin
					upd.op  = lfr_pkg::UPD_PIN;
					upd.pin = 1'b1;
				end
				lfr_pkg::CMD_UNPIN: begin
					upd.op  = lfr_pkg::UPD_PIN;
					upd.pin = 1'b0;
				end
				default: begin
				end
			endcase
		end
		// hold the cells until the result can be stored
		if (!apply_go) begin
			upd.op = lfr_pkg::UPD_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cnt_q   <= '0;
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					if (cnt_q == IDX_W'(NUM_FRAMES - 1)) begin
						state_q <= S_APPLY;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_APPLY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= s_tuser;
			key_q <= key_wide[PAGE_ID_BITS-1:0];
			pin_q <= s_tdata[PORT_PW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q     <= lfr_pkg::POOL_RESET;
			used_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pool_q <= cfg_data;
			end
			if (upd.op == lfr_pkg::UPD_FRESH) begin
				used_q <= used_q + 1'b1;
			end
			if (apply_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go) begin
			frame_q  <= FRAME_W'(nfr);
			status_q <= nstat;
			ev_q     <= nev;
			evpage_q <= ev_wide[PORT_PW-1:0];
		end
	end

	`LFR_ASSERT_NXT(a_apply_loads_result, apply_go, m_tvalid_q && (state_q == S_IDLE), "apply step did not deliver a result")
	`LFR_ASSERT_IMP(a_used_bound, 1'b1, used_q <= CNT_W'(NUM_FRAMES), "frames in use exceed the frame count")
	`LFR_ASSERT_IMP(a_error_clean, m_tvalid_q && (status_q != lfr_pkg::STAT_OK), (frame_q == '0) && !ev_q, "error result carries frame or eviction")
	`LFR_ASSERT_IMP(a_update_only_in_apply, state_q != S_APPLY, upd.op == lfr_pkg::UPD_NONE, "cells updated outside the apply step")
endmodule
